// ----- design/tpp_pkg.sv -----
// shared constants and the helper function for the truecolor pixel packer
package tpp_pkg;

  localparam int PIXEL_WIDTH_DEF = 32;
  localparam int CH_MAX_W        = 32;
  localparam int FLOOR_W         = 16;
  localparam int SAMPLE_W        = 8;
  localparam int PROD_W          = 24;
  localparam int CNT_W           = 6;
  localparam int CFG_IDX_W       = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_RED_MASK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MASK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_MASK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_FLOOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_FLOOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_FLOOR  = 3'd5;

  localparam logic [CH_MAX_W-1:0] RED_MASK_RST   = 32'h00FF_0000;
  localparam logic [CH_MAX_W-1:0] GREEN_MASK_RST = 32'h0000_FF00;
  localparam logic [CH_MAX_W-1:0] BLUE_MASK_RST  = 32'h0000_00FF;
  localparam logic [FLOOR_W-1:0]  FLOOR_RST      = 16'h1000;

  localparam logic [FLOOR_W-1:0]  FULL_SCALE     = 16'hFFFF;
  // ceil(2^31 / 255), exact floor division for products below 2^24
  localparam logic [PROD_W-1:0]   RECIP_255      = 24'h80_8081;
  localparam int                  RECIP_SHIFT    = 31;

  // number of trailing zeros, 32 when the word is zero
  function automatic logic [CNT_W-1:0] ctz32(input logic [CH_MAX_W-1:0] x);
    logic [CNT_W-1:0] cnt;
    cnt = CNT_W'(CH_MAX_W);
    for (int i = CH_MAX_W - 1; i >= 0; i--) begin
      if (x[i]) begin
        cnt = CNT_W'(i);
      end
    end
    return cnt;
  endfunction

endpackage

// ----- design/tpp_lane.sv -----
// one color channel: scale the sample to 16 bits and place it under its mask
module tpp_lane import tpp_pkg::*; #(
  parameter int MASK_W = CH_MAX_W
) (
  input  logic                clk,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [FLOOR_W-1:0]  floor_v,
  input  logic [MASK_W-1:0]   mask,
  output logic [CH_MAX_W-1:0] lane_word
);

  logic [CH_MAX_W-1:0]   mask32;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [CNT_W-1:0]      pos_r, pos_nxt;
  logic                  zero_r, zero_nxt;
  logic [FLOOR_W-1:0]    quot_r, quot_nxt;
  logic [CNT_W-1:0]      top_r, top_nxt;
  logic [CH_MAX_W-1:0]   word_r, word_nxt;
  logic [2*PROD_W-1:0]   scaled;
  logic [CH_MAX_W-1:0]   below_pos;
  logic [FLOOR_W-1:0]    level;
  logic [CH_MAX_W-1:0]   level32;
  logic [CH_MAX_W-1:0]   placed;

  assign mask32 = CH_MAX_W'(mask);

  // stage 1: scale product and lowest set bit of the mask
  assign prod_nxt = PROD_W'(FULL_SCALE - floor_v) * PROD_W'(sample);
  assign pos_nxt  = ctz32(mask32);
  assign zero_nxt = (mask32 == '0);

  // stage 2: divide by 255 through the reciprocal, find the top of the lowest run
  assign scaled    = {{PROD_W{1'b0}}, prod_r} * {{PROD_W{1'b0}}, RECIP_255};
  assign quot_nxt  = scaled[RECIP_SHIFT+FLOOR_W-1:RECIP_SHIFT];
  assign below_pos = (CH_MAX_W'(1) << pos_r) - CH_MAX_W'(1);
  assign top_nxt   = zero_r ? '0 : ctz32(~(mask32 | below_pos));

  // stage 3: add the floor, align the top of the value to the top of the run
  assign level   = quot_r + floor_v;
  assign level32 = CH_MAX_W'(level);
  always_comb begin
    if (top_r <= CNT_W'(FLOOR_W)) begin
      placed = level32 >> (CNT_W'(FLOOR_W) - top_r);
    end else begin
      placed = level32 << (top_r - CNT_W'(FLOOR_W));
    end
  end
  assign word_nxt = placed & mask32;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    pos_r  <= pos_nxt;
    zero_r <= zero_nxt;
    quot_r <= quot_nxt;
    top_r  <= top_nxt;
    word_r <= word_nxt;
  end

  assign lane_word = word_r;

endmodule

// ----- design/tpp_merge.sv -----
// merges the three channel words into the registered output pixel
module tpp_merge import tpp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_in,
  input  logic [CH_MAX_W-1:0] red_word,
  input  logic [CH_MAX_W-1:0] green_word,
  input  logic [CH_MAX_W-1:0] blue_word,
  output logic                valid_out,
  output logic [CH_MAX_W-1:0] pixel
);

  logic                valid_r;
  logic [CH_MAX_W-1:0] pixel_r, pixel_nxt;

  assign pixel_nxt = red_word | green_word | blue_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    pixel_r <= pixel_nxt;
  end

  assign valid_out = valid_r;
  assign pixel     = pixel_r;

endmodule

// ----- design/truecolor_pixel_packer.sv -----
// top level of the truecolor pixel packer: config registers, channel lanes, merge
// Takes one RGB888 sample per clock and returns the packed display pixel,
// registered through the lane stages and the merge register, on
// out_packed_pixel with out_valid high for one cycle; the rate is one pixel per
// clock with no gaps, set by the three channel lanes (multiply, reciprocal divide
// by 255, align and mask) running side by side and a merge register that ORs
// them. busy stays low, so start may be held high continuously. The receiver
// cannot stall, so it must take every beat.
// Change cfg_ registers only while no pixel is in flight.
module truecolor_pixel_packer import tpp_pkg::*; #(
  parameter int PIXEL_WIDTH = PIXEL_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [SAMPLE_W-1:0]  in_red_in,
  input  logic [SAMPLE_W-1:0]  in_green_in,
  input  logic [SAMPLE_W-1:0]  in_blue_in,
  output logic                 out_valid,
  output logic [CH_MAX_W-1:0]  out_packed_pixel,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CH_MAX_W-1:0]  cfg_wdata
);

  localparam int MASK_W = (PIXEL_WIDTH < CH_MAX_W) ? PIXEL_WIDTH : CH_MAX_W;

  logic [MASK_W-1:0]   red_mask_r, green_mask_r, blue_mask_r;
  logic [FLOOR_W-1:0]  red_floor_r, green_floor_r, blue_floor_r;
  logic [2:0]          stage_vld_r, stage_vld_nxt;
  logic                accept;
  logic [CH_MAX_W-1:0] red_word, green_word, blue_word;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_mask_r    <= RED_MASK_RST[MASK_W-1:0];
      green_mask_r  <= GREEN_MASK_RST[MASK_W-1:0];
      blue_mask_r   <= BLUE_MASK_RST[MASK_W-1:0];
      red_floor_r   <= FLOOR_RST;
      green_floor_r <= FLOOR_RST;
      blue_floor_r  <= FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RED_MASK:    red_mask_r    <= cfg_wdata[MASK_W-1:0];
        CFG_GREEN_MASK:  green_mask_r  <= cfg_wdata[MASK_W-1:0];
        CFG_BLUE_MASK:   blue_mask_r   <= cfg_wdata[MASK_W-1:0];
        CFG_RED_FLOOR:   red_floor_r   <= cfg_wdata[FLOOR_W-1:0];
        CFG_GREEN_FLOOR: green_floor_r <= cfg_wdata[FLOOR_W-1:0];
        CFG_BLUE_FLOOR:  blue_floor_r  <= cfg_wdata[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits that follow the beat through the three lane stages
  assign stage_vld_nxt = {stage_vld_r[1:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= '0;
    end else begin
      stage_vld_r <= stage_vld_nxt;
    end
  end

  tpp_lane #(.MASK_W(MASK_W)) u_red (
    .clk       (clk),
    .sample    (in_red_in),
    .floor_v   (red_floor_r),
    .mask      (red_mask_r),
    .lane_word (red_word)
  );

  tpp_lane #(.MASK_W(MASK_W)) u_green (
    .clk       (clk),
    .sample    (in_green_in),
    .floor_v   (green_floor_r),
    .mask      (green_mask_r),
    .lane_word (green_word)
  );

  tpp_lane #(.MASK_W(MASK_W)) u_blue (
    .clk       (clk),
    .sample    (in_blue_in),
    .floor_v   (blue_floor_r),
    .mask      (blue_mask_r),
    .lane_word (blue_word)
  );

  tpp_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_in   (stage_vld_r[2]),
    .red_word   (red_word),
    .green_word (green_word),
    .blue_word  (blue_word),
    .valid_out  (out_valid),
    .pixel      (out_packed_pixel)
  );

  a_out_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 4))
    else $error("result beat without a matching start");

  a_accept_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("accepted beat did not produce a result");

  a_stage_chain: assert property (@(posedge clk) disable iff (!rst_n)
    stage_vld_r[2] |-> $past(stage_vld_r[1]))
    else $error("lane valid chain skipped a stage");

endmodule

// ----- test/tb_truecolor_pixel_packer.sv -----
// self-checking testbench for truecolor_pixel_packer with a queue-fed driver and monitor
module tb_truecolor_pixel_packer import tpp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF     = 2;
  localparam int RST_CYCLES   = 5;
  localparam int PIPE_LATENCY = 4;
  localparam int LIMIT_CYCLES = 200_000;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_BEATS  = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef enum logic [1:0] {JOB_PIXEL, JOB_WRITE, JOB_DRAIN, JOB_IDLE_LEVEL} job_kind_t;

  typedef struct {
    job_kind_t             kind;
    logic [SAMPLE_W-1:0]   red;
    logic [SAMPLE_W-1:0]   green;
    logic [SAMPLE_W-1:0]   blue;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CH_MAX_W-1:0]   data;
    int unsigned           pct;
  } job_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [SAMPLE_W-1:0]  in_red_in = '0;
  logic [SAMPLE_W-1:0]  in_green_in = '0;
  logic [SAMPLE_W-1:0]  in_blue_in = '0;
  logic                 out_valid;
  logic [CH_MAX_W-1:0]  out_packed_pixel;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CH_MAX_W-1:0]  cfg_wdata = '0;

  job_t                pending_jobs_q[$];
  logic [CH_MAX_W-1:0] pixel_due_q[$];

  logic [CH_MAX_W-1:0] red_mask_sh, green_mask_sh, blue_mask_sh;
  logic [FLOOR_W-1:0]  red_floor_sh, green_floor_sh, blue_floor_sh;

  logic        pix_taken = 1'b0;
  int unsigned idle_pct = 0;
  int unsigned err_cnt = 0;
  int unsigned n_checked = 0;
  int unsigned n_writes = 0;
  int unsigned n_settings = 1;
  int unsigned cycles = 0;

  truecolor_pixel_packer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_red_in        (in_red_in),
    .in_green_in      (in_green_in),
    .in_blue_in       (in_blue_in),
    .out_valid        (out_valid),
    .out_packed_pixel (out_packed_pixel),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic logic [CH_MAX_W-1:0] place_lane(input logic [CH_MAX_W-1:0] mask,
                                                     input logic [FLOOR_W-1:0] flr,
                                                     input logic [SAMPLE_W-1:0] c);
    int          pos;
    int          run;
    int          sh;
    logic [63:0] v;
    pos = 0;
    run = 0;
    if (mask != '0) begin
      while (!mask[pos]) pos++;
      while (pos + run < CH_MAX_W && mask[pos + run]) run++;
    end
    v = (64'(FULL_SCALE - flr) * c) / 64'd255 + 64'(flr);
    sh = 16 - pos - run;
    if (sh > 0) begin
      v = v >> sh;
    end else begin
      v = v << (-sh);
    end
    return v[CH_MAX_W-1:0] & mask;
  endfunction

  function automatic logic [CH_MAX_W-1:0] packed_pixel_of(input logic [SAMPLE_W-1:0] r,
                                                          input logic [SAMPLE_W-1:0] g,
                                                          input logic [SAMPLE_W-1:0] b);
    return place_lane(red_mask_sh, red_floor_sh, r) |
           place_lane(green_mask_sh, green_floor_sh, g) |
           place_lane(blue_mask_sh, blue_floor_sh, b);
  endfunction

  always @(negedge clk) begin : drive
    job_t head;
    logic nxt_start;
    logic nxt_we;
    nxt_start = start && !pix_taken;
    nxt_we = 1'b0;
    if (rst_n && !nxt_start && pending_jobs_q.size() != 0) begin
      head = pending_jobs_q[0];
      case (head.kind)
        JOB_IDLE_LEVEL: begin
          idle_pct = head.pct;
          void'(pending_jobs_q.pop_front());
        end
        JOB_DRAIN: begin
          if (pixel_due_q.size() == 0) void'(pending_jobs_q.pop_front());
        end
        JOB_WRITE: begin
          if (pixel_due_q.size() == 0) begin
            void'(pending_jobs_q.pop_front());
            nxt_we = 1'b1;
            cfg_index <= head.idx;
            cfg_wdata <= head.data;
          end
        end
        JOB_PIXEL: begin
          if ($urandom_range(99) >= idle_pct) begin
            void'(pending_jobs_q.pop_front());
            nxt_start = 1'b1;
            in_red_in <= head.red;
            in_green_in <= head.green;
            in_blue_in <= head.blue;
          end
        end
        default: ;
      endcase
    end
    start <= nxt_start;
    cfg_we <= nxt_we;
  end

  always @(posedge clk) begin : monitor
    logic [CH_MAX_W-1:0] want;
    if (!rst_n) begin
      red_mask_sh = RED_MASK_RST;
      green_mask_sh = GREEN_MASK_RST;
      blue_mask_sh = BLUE_MASK_RST;
      red_floor_sh = FLOOR_RST;
      green_floor_sh = FLOOR_RST;
      blue_floor_sh = FLOOR_RST;
      pix_taken <= 1'b0;
    end else begin
      if (cfg_we) begin
        n_writes++;
        case (cfg_index)
          CFG_RED_MASK:    red_mask_sh = cfg_wdata;
          CFG_GREEN_MASK:  green_mask_sh = cfg_wdata;
          CFG_BLUE_MASK:   blue_mask_sh = cfg_wdata;
          CFG_RED_FLOOR:   red_floor_sh = cfg_wdata[FLOOR_W-1:0];
          CFG_GREEN_FLOOR: green_floor_sh = cfg_wdata[FLOOR_W-1:0];
          CFG_BLUE_FLOOR:  blue_floor_sh = cfg_wdata[FLOOR_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        pixel_due_q.push_back(packed_pixel_of(in_red_in, in_green_in, in_blue_in));
      end
      pix_taken <= start && !busy;
      if (out_valid) begin
        if (pixel_due_q.size() == 0) begin
          if (err_cnt < MAX_REPORTS) begin
            $display("unexpected beat: packed_pixel %08h", out_packed_pixel);
          end
          err_cnt++;
        end else begin
          want = pixel_due_q.pop_front();
          if (out_packed_pixel !== want) begin
            if (err_cnt < MAX_REPORTS) begin
              $display("pixel %0d packed_pixel mismatch: expected %08h got %08h",
                       n_checked, want, out_packed_pixel);
            end
            err_cnt++;
          end
          n_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("truecolor_pixel_packer test failed");
      $finish;
    end
  end

  task automatic add_pixel(input logic [SAMPLE_W-1:0] r, input logic [SAMPLE_W-1:0] g,
                           input logic [SAMPLE_W-1:0] b);
    job_t j;
    j.kind = JOB_PIXEL;
    j.red = r;
    j.green = g;
    j.blue = b;
    pending_jobs_q.push_back(j);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CH_MAX_W-1:0] data);
    job_t j;
    j.kind = JOB_WRITE;
    j.idx = idx;
    j.data = data;
    pending_jobs_q.push_back(j);
  endtask

  task automatic add_marker(input job_kind_t kind, input int unsigned pct);
    job_t j;
    j.kind = kind;
    j.pct = pct;
    pending_jobs_q.push_back(j);
  endtask

  task automatic write_setting(input logic [CH_MAX_W-1:0] rm, input logic [CH_MAX_W-1:0] gm,
                               input logic [CH_MAX_W-1:0] bm, input logic [CH_MAX_W-1:0] rf,
                               input logic [CH_MAX_W-1:0] gf, input logic [CH_MAX_W-1:0] bf);
    add_write(CFG_RED_MASK, rm);
    add_write(CFG_GREEN_MASK, gm);
    add_write(CFG_BLUE_MASK, bm);
    add_write(CFG_RED_FLOOR, rf);
    add_write(CFG_GREEN_FLOOR, gf);
    add_write(CFG_BLUE_FLOOR, bf);
    n_settings++;
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [CH_MAX_W-1:0] rand_mask();
    int w;
    int p;
    w = $urandom_range(CH_MAX_W, 1);
    p = $urandom_range(CH_MAX_W - w, 0);
    case ($urandom_range(9))
      0:       return '0;
      1:       return $urandom();
      default: return CH_MAX_W'(((64'd1 << w) - 64'd1) << p);
    endcase
  endfunction

  function automatic logic [CH_MAX_W-1:0] rand_floor();
    case ($urandom_range(5))
      0:       return {16'($urandom()), 16'h0000};
      1:       return {16'($urandom()), 16'hFFFF};
      default: return $urandom();
    endcase
  endfunction

  task automatic add_phases();
    int unsigned levels[4];
    levels = '{0, 67, 0, 16};
    foreach (levels[k]) begin
      add_marker(JOB_IDLE_LEVEL, levels[k]);
      repeat (PHASE_BEATS) add_pixel(rand_sample(), rand_sample(), rand_sample());
      if (k == 1) add_marker(JOB_DRAIN, 0);
    end
  endtask

  initial begin
    // reset settings: corners and walking ones on every sample bit
    add_pixel(8'h00, 8'h00, 8'h00);
    add_pixel(8'hFF, 8'hFF, 8'hFF);
    add_pixel(8'hFF, 8'h00, 8'h00);
    add_pixel(8'h00, 8'hFF, 8'h00);
    add_pixel(8'h00, 8'h00, 8'hFF);
    for (int k = 0; k < SAMPLE_W; k++) begin
      add_pixel(8'd1 << k, 8'd1 << ((k + 3) % SAMPLE_W), 8'd1 << ((k + 5) % SAMPLE_W));
    end
    add_pixel(8'h80, 8'h7F, 8'h01);
    add_pixel(8'hFE, 8'h01, 8'h80);
    add_phases();

    // 565 layout, zero floors
    write_setting(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, '0, '0, '0);
    add_pixel(8'hFF, 8'hFF, 8'hFF);
    add_phases();

    // full-width mask, zero mask, top bit with large left shift; junk above floor width
    write_setting(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000,
                  32'hABCD_FFFF, 32'hFFFF_0000, 32'h0000_FFFF);
    add_pixel(8'hFF, 8'hFF, 8'hFF);
    add_pixel(8'h00, 8'hFF, 8'h00);
    add_phases();

    // masks with several runs of ones, writes to unused indexes are ignored
    write_setting(32'h0F0F_0000, 32'h0000_F0F0, 32'h0000_0033, 32'h1000, 32'h0, 32'hFFFF);
    add_write(CFG_SPARE_A, $urandom());
    add_write(CFG_SPARE_B, $urandom());
    add_phases();

    repeat (5) begin
      write_setting(rand_mask(), rand_mask(), rand_mask(), rand_floor(), rand_floor(),
                    rand_floor());
      add_phases();
    end

    repeat (RST_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_jobs_q.size() != 0 || start || pixel_due_q.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 4) @(negedge clk);

    $display("checked %0d pixels over %0d register settings (%0d register writes)",
             n_checked, n_settings, n_writes);
    $display("sender idle levels 0, 16 and 67 percent, %0d mismatches", err_cnt);
    if (err_cnt == 0 && pixel_due_q.size() == 0) begin
      $display("truecolor_pixel_packer test passed");
    end else begin
      $display("truecolor_pixel_packer test failed");
    end
    $finish;
  end

endmodule
